>>> rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MagWidth   = ValueWidth;
  // decimal digits of 2**ValueWidth, log10(2) taken as 1233/4096
  localparam int unsigned NumDigits  = ((ValueWidth * 1233) >> 12) + 1;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CntWidth   = $clog2(NumDigits + 1);
  // double dabble work is split over this many pipeline stages
  localparam int unsigned NumStages  = 4;
  localparam int unsigned BitsPerStage = (MagWidth + NumStages - 1) / NumStages;

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  typedef struct packed {
    logic                 neg;
    logic [MagWidth-1:0]  mag;
    logic [BcdWidth-1:0]  bcd;
  } dd_stage_t;

  // one shift-add-3 step of double dabble
  function automatic logic [BcdWidth+MagWidth-1:0] dd_step(
    input logic [BcdWidth+MagWidth-1:0] w
  );
    logic [BcdWidth+MagWidth-1:0] r;
    r = w;
    for (int d = 0; d < NumDigits; d++) begin
      if (r[MagWidth+4*d +: 4] >= 4'd5) begin
        r[MagWidth+4*d +: 4] = r[MagWidth+4*d +: 4] + 4'd3;
      end
    end
    return {r[BcdWidth+MagWidth-2:0], 1'b0};
  endfunction

endpackage

>>> rtl/int_to_decimal_ascii_top.sv
// int_to_decimal_ascii_top
// Converts a signed 32-bit integer into its decimal ASCII text.
// Input channel: value_i with valid_i/ready_o, one integer per beat.
// Output channel: ascii_char_o and last_o with valid_o/ready_i, one
// character per beat, most significant first, '-' ahead of a negative
// number, no leading zeros, last_o high on the final character.
// Path: an integer passes a sign stage and four binary-to-bcd stages
// (8 bits each), then sits in the emit register, from which its first
// character is shown on the output.
// Throughput: the emit register sends one character per cycle while ready_i
// is high; that register sets the rate. The front pipeline accepts
// a new integer every cycle while it has room.
// Reset clears all valid bits; no payload is held across reset.
// When the receiver stalls, the current character holds and the pipeline
// fills up and then drops ready_o; nothing is lost or repeated.
module int_to_decimal_ascii_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [itoa_pkg::ValueWidth-1:0] value_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [itoa_pkg::CharWidth-1:0]  ascii_char_o,
  output logic                            last_o
);
  import itoa_pkg::*;

  dd_stage_t st_q  [NumStages+1];
  dd_stage_t st_d  [NumStages+1];
  logic      vld_q [NumStages+1];
  logic      adv   [NumStages+1];

  // emit register
  logic                 e_vld_q, e_vld_d;
  logic                 e_neg_q, e_neg_d;
  logic [BcdWidth-1:0]  e_bcd_q, e_bcd_d;
  logic [CntWidth-1:0]  e_cnt_q, e_cnt_d;   // digits still to send
  logic                 e_load;
  logic                 out_fire;
  logic                 e_done;
  logic [CntWidth-1:0]  nz_cnt;
  logic [CntWidth-1:0]  cnt_m1;

  assign out_fire = e_vld_q && ready_i;
  // item finishes when no sign is pending and only one digit remains
  assign e_done   = out_fire && !e_neg_q && (e_cnt_q == CntWidth'(1));
  assign e_load   = vld_q[NumStages] && (!e_vld_q || e_done);

  // stage 0 takes the input, stage k applies BitsPerStage dabble steps
  always_comb begin
    adv[NumStages] = e_load;
    for (int s = NumStages - 1; s >= 0; s--) begin
      adv[s] = vld_q[s] && (!vld_q[s+1] || adv[s+1]);
    end
  end
  assign ready_o = !vld_q[0] || adv[0];

  always_comb begin
    logic [BcdWidth+MagWidth-1:0] w;
    st_d[0].neg = value_i[ValueWidth-1];
    st_d[0].mag = value_i[ValueWidth-1] ? (~value_i + MagWidth'(1)) : value_i;
    st_d[0].bcd = '0;
    for (int s = 1; s <= NumStages; s++) begin
      w = {st_q[s-1].bcd, st_q[s-1].mag};
      for (int b = 0; b < BitsPerStage; b++) begin
        if ((s - 1) * BitsPerStage + b < MagWidth) begin
          w = dd_step(w);
        end
      end
      st_d[s].neg = st_q[s-1].neg;
      st_d[s].mag = w[MagWidth-1:0];
      st_d[s].bcd = w[BcdWidth+MagWidth-1:MagWidth];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NumStages; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      if (ready_o) begin
        vld_q[0] <= valid_i;
      end
      for (int s = 1; s <= NumStages; s++) begin
        if (!vld_q[s] || adv[s]) begin
          vld_q[s] <= adv[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      st_q[0] <= st_d[0];
    end
    for (int s = 1; s <= NumStages; s++) begin
      if (adv[s-1] && (!vld_q[s] || adv[s])) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // count significant digits, at least one
  always_comb begin
    nz_cnt = CntWidth'(1);
    for (int d = 1; d < NumDigits; d++) begin
      if (st_q[NumStages].bcd[4*d +: 4] != 4'd0) begin
        nz_cnt = CntWidth'(d + 1);
      end
    end
  end

  assign cnt_m1 = e_cnt_q - CntWidth'(1);

  always_comb begin
    e_vld_d = e_vld_q;
    e_neg_d = e_neg_q;
    e_bcd_d = e_bcd_q;
    e_cnt_d = e_cnt_q;
    if (e_load) begin
      e_vld_d = 1'b1;
      e_neg_d = st_q[NumStages].neg;
      e_bcd_d = st_q[NumStages].bcd;
      e_cnt_d = nz_cnt;
    end else if (e_done) begin
      e_vld_d = 1'b0;
    end else if (out_fire) begin
      if (e_neg_q) begin
        e_neg_d = 1'b0;
      end else begin
        e_cnt_d = cnt_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      e_neg_q <= 1'b0;
      e_cnt_q <= '0;
    end else begin
      e_vld_q <= e_vld_d;
      e_neg_q <= e_neg_d;
      e_cnt_q <= e_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_bcd_q <= e_bcd_d;
  end

  assign valid_o      = e_vld_q;
  assign ascii_char_o = e_neg_q ? CharMinus
                                : (CharZero | {4'd0, e_bcd_q[4*cnt_m1[CntWidth-1:0] +: 4]});
  assign last_o       = !e_neg_q && (e_cnt_q == CntWidth'(1));

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q |-> (e_cnt_q != '0) && (e_cnt_q <= CntWidth'(NumDigits)))
    else $error("digit count out of range");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q && !ready_i |=> e_vld_q && $stable(e_cnt_q) && $stable(e_neg_q))
    else $error("emit state moved during stall");
  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q && e_neg_q |-> !last_o)
    else $error("sign flagged as last");
  a_digit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !e_neg_q |-> ascii_char_o <= 8'd57)
    else $error("bad digit");

endmodule

>>> tb/tb.sv
module tb;
  import itoa_pkg::*;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } char_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  valid_i = 1'b0;
  logic                  ready_o;
  logic [ValueWidth-1:0] value_i = '0;
  logic                  valid_o;
  logic                  ready_i = 1'b0;
  logic [CharWidth-1:0]  ascii_char_o;
  logic                  last_o;

  char_beat_t expected_chars[$];
  int unsigned n_errors = 0;
  int unsigned n_values = 0;
  int unsigned n_chars = 0;
  int unsigned n_cycles = 0;
  int unsigned hold_off = 0;
  int unsigned sink_wait = 0;
  bit          took_beat = 1'b0;
  bit          sink_random = 1'b1;

  localparam int unsigned CycleLimit = 400000;

  int_to_decimal_ascii_top dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .value_i,
    .valid_o, .ready_i, .ascii_char_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decimal text of a two's-complement value, sign first
  task automatic predict_text(input logic [ValueWidth-1:0] v);
    logic                  neg;
    logic [ValueWidth-1:0] mag;
    logic [CharWidth-1:0]  digs[$];
    char_beat_t            b;
    neg = v[ValueWidth-1];
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digs.push_front(CharZero + CharWidth'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      b.ch = CharMinus;
      b.last = 1'b0;
      expected_chars.push_back(b);
    end
    foreach (digs[i]) begin
      b.ch = digs[i];
      b.last = (i == digs.size() - 1);
      expected_chars.push_back(b);
    end
  endtask

  task automatic send_value(input logic [ValueWidth-1:0] v, input bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk_i);
    valid_i = 1'b1;
    value_i = v;
    predict_text(v);
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    n_values++;
    @(negedge clk_i);
    valid_i = 1'b0;
  endtask

  // random value spread over all digit counts
  function automatic logic [ValueWidth-1:0] rand_value();
    logic [ValueWidth-1:0] v;
    int unsigned sh;
    v = $urandom();
    sh = $urandom_range(0, ValueWidth - 1);
    case ($urandom_range(0, 3))
      0: v = v >> sh;
      1: v = -(v >> sh);
      default: ;
    endcase
    return v;
  endfunction

  // receiver: random wait after each beat, or a forced hold-off
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!sink_random) begin
      ready_i <= 1'b1;
    end else if (sink_wait != 0) begin
      ready_i <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else if (!ready_i) begin
      ready_i <= 1'b1;
    end else if (took_beat) begin
      int unsigned w;
      w = $urandom_range(0, 5);
      if (w != 0) begin
        ready_i <= 1'b0;
        sink_wait <= w - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    took_beat <= rst_ni && valid_o && ready_i;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && valid_o && ready_i) begin
      n_chars <= n_chars + 1;
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: ascii_char %0d last %0b", ascii_char_o, last_o);
        n_errors++;
      end else begin
        char_beat_t e;
        e = expected_chars.pop_front();
        if (ascii_char_o !== e.ch) begin
          $error("ascii_char expected %0d actual %0d", e.ch, ascii_char_o);
          n_errors++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0b actual %0b", e.last, last_o);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [ValueWidth-1:0] vals[$];
    vals = '{32'd0, 32'd1, 32'd9, 32'd10, -32'sd1, -32'sd5, -32'sd9, -32'sd10,
             32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd999_999_999,
             32'd1_000_000_000, -32'sd1_000_000_000, 32'd100, 32'hffff_fff6,
             32'h5555_5555, 32'haaaa_aaaa, 32'd123456789, -32'sd987654321};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_back_to_back();
    sink_random = 1'b0;
    repeat (40) send_value(rand_value(), 1'b1);
    sink_random = 1'b1;
  endtask

  // long receiver stall while values keep coming, so ready_o must drop
  task automatic test_backpressure();
    hold_off = 300;
    repeat (30) send_value(rand_value(), 1'b1);
  endtask

  task automatic test_random();
    repeat (320) send_value(rand_value());
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_back_to_back();
    test_backpressure();
    test_random();
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("converted %0d values into %0d characters, incl. extremes, stalls and",
             n_values, n_chars);
    $display("a long receiver hold-off; %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
